>>> design/escape_sequence_decoder_defines.svh
// ----------------------------------------------------------------------------
// escape sequence decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// same-cycle implication, reset masked
`define ESD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape sequence decoder check failed");

// next-cycle implication, reset masked
`define ESD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape sequence decoder check failed");

`endif

>>> design/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the escape sequence decoder
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

	localparam int ESD_QUEUE_DEPTH = 4;
	localparam int MAX_RESULTS     = 3;
	localparam logic [15:0] CAP_RESET = 16'd256;

	// one output word
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_written;
		logic        end_of_string;
		logic [15:0] decoded_length;
	} result_t;

	// all words caused by one input character
	typedef struct packed {
		logic [1:0]                    n_words;
		result_t [MAX_RESULTS-1:0]     words;
	} bundle_t;

endpackage

`default_nettype wire

>>> design/esd_in_if.sv
// ----------------------------------------------------------------------------
// esd_in_if
// character channel: valid/ready plus one escaped source character
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

`default_nettype wire

>>> design/esd_out_if.sv
// ----------------------------------------------------------------------------
// esd_out_if
// result channel: valid/ready plus one decoded word
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_written;
	logic        end_of_string;
	logic [15:0] decoded_length;

	modport source (output valid, output out_byte, output byte_written,
		output end_of_string, output decoded_length, input ready);
	modport sink   (input valid, input out_byte, input byte_written,
		input end_of_string, input decoded_length, output ready);
endinterface

`default_nettype wire

>>> design/esd_front.sv
// ----------------------------------------------------------------------------
// esd_front
// escape state machine: classifies each character and builds its words
// ----------------------------------------------------------------------------
`default_nettype none

module esd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      char_in,
	input  wire logic            is_last,
	input  wire logic [15:0]     out_capacity,
	output esd_pkg::bundle_t     bundle,
	output logic                 push
);
	import esd_pkg::*;

	typedef enum logic [5:0] {
		PH_NORMAL = 6'b000001,
		PH_ESC    = 6'b000010,
		PH_HEX0   = 6'b000100,
		PH_HEX1   = 6'b001000,
		PH_OCT1   = 6'b010000,
		PH_OCT2   = 6'b100000
	} phase_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] BY_NL     = 8'h0A;
	localparam logic [7:0] BY_CR     = 8'h0D;
	localparam logic [7:0] BY_TAB    = 8'h09;
	localparam logic [7:0] BY_ESC    = 8'h1B;

	phase_t      phase_q;
	logic [8:0]  value_q;
	logic [15:0] count_q;
	logic        full_q;

	phase_t      ph_a, ph_b;
	logic [8:0]  val_a, val_b;
	logic        do_new, full_b;
	logic        pend_emit, new_emit, flush_emit;
	logic [7:0]  pend_byte;
	logic [15:0] cnt_a, cnt_b, cnt_c;
	logic        is_hex, is_oct;
	logic [3:0]  hex_v;
	logic [2:0]  oct_d;
	logic [1:0]  n;
	result_t [MAX_RESULTS-1:0] words;

	always_comb begin
		is_hex = 1'b0;
		hex_v  = 4'd0;
		if (char_in inside {[8'h30:8'h39]}) begin
			is_hex = 1'b1;
			hex_v  = char_in[3:0];
		end else if (char_in inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			is_hex = 1'b1;
			hex_v  = 4'(char_in[3:0] + 4'd9);
		end
		is_oct = char_in inside {[8'h30:8'h37]};
		oct_d  = char_in[2:0];
	end

	// pending escape, then a possible new item, then end-of-string flush
	always_comb begin
		ph_a      = phase_q;
		val_a     = value_q;
		do_new    = 1'b0;
		pend_emit = 1'b0;
		pend_byte = 8'd0;
		if (!full_q) begin
			case (phase_q)
				PH_ESC: begin
					ph_a = PH_NORMAL;
					case (char_in)
						CH_BSLASH: begin pend_emit = 1'b1; pend_byte = CH_BSLASH; end
						CH_QUOTE:  begin pend_emit = 1'b1; pend_byte = CH_QUOTE;  end
						CH_N:      begin pend_emit = 1'b1; pend_byte = BY_NL;     end
						CH_R:      begin pend_emit = 1'b1; pend_byte = BY_CR;     end
						CH_T:      begin pend_emit = 1'b1; pend_byte = BY_TAB;    end
						CH_E:      begin pend_emit = 1'b1; pend_byte = BY_ESC;    end
						CH_X: begin
							ph_a  = PH_HEX0;
							val_a = 9'd0;
						end
						default: begin
							if (is_oct) begin
								ph_a  = PH_OCT1;
								val_a = {6'd0, oct_d};
							end else begin
								do_new = 1'b1;
							end
						end
					endcase
				end
				PH_HEX0: begin
					if (is_hex) begin
						ph_a  = PH_HEX1;
						val_a = {5'd0, hex_v};
					end else begin
						do_new = 1'b1;
					end
				end
				PH_HEX1: begin
					ph_a      = PH_NORMAL;
					pend_emit = 1'b1;
					if (is_hex) begin
						pend_byte = {value_q[3:0], hex_v};
						val_a     = 9'd0;
					end else begin
						pend_byte = value_q[7:0];
						do_new    = 1'b1;
					end
				end
				PH_OCT1: begin
					if (is_oct) begin
						ph_a  = PH_OCT2;
						val_a = {value_q[5:0], oct_d};
					end else begin
						ph_a      = PH_NORMAL;
						pend_emit = 1'b1;
						pend_byte = value_q[7:0];
						do_new    = 1'b1;
					end
				end
				PH_OCT2: begin
					ph_a      = PH_NORMAL;
					pend_emit = 1'b1;
					if (is_oct) begin
						pend_byte = {value_q[4:0], oct_d};
						val_a     = 9'd0;
					end else begin
						pend_byte = value_q[7:0];
						do_new    = 1'b1;
					end
				end
				default: do_new = 1'b1;
			endcase
		end

		cnt_a = count_q + {15'd0, pend_emit};

		// new item: capacity check first
		ph_b     = ph_a;
		val_b    = val_a;
		full_b   = full_q;
		new_emit = 1'b0;
		if (do_new) begin
			ph_b  = PH_NORMAL;
			val_b = 9'd0;
			if ({1'b0, cnt_a} + 17'd1 >= {1'b0, out_capacity}) begin
				full_b = 1'b1;
			end else if (char_in == CH_BSLASH) begin
				ph_b = PH_ESC;
			end else begin
				new_emit = 1'b1;
			end
		end
		cnt_b = cnt_a + {15'd0, new_emit};

		flush_emit = is_last && !full_b &&
			(ph_b == PH_HEX1 || ph_b == PH_OCT1 || ph_b == PH_OCT2);
		cnt_c = cnt_b + {15'd0, flush_emit};

		// pack the words in order
		words = '0;
		n     = 2'd0;
		if (pend_emit) begin
			words[n] = '{out_byte: pend_byte, byte_written: 1'b1,
				end_of_string: 1'b0, decoded_length: cnt_a};
			n = n + 2'd1;
		end
		if (new_emit) begin
			words[n] = '{out_byte: char_in, byte_written: 1'b1,
				end_of_string: 1'b0, decoded_length: cnt_b};
			n = n + 2'd1;
		end
		if (flush_emit) begin
			words[n] = '{out_byte: val_b[7:0], byte_written: 1'b1,
				end_of_string: 1'b0, decoded_length: cnt_c};
			n = n + 2'd1;
		end
		if (is_last) begin
			words[n] = '{out_byte: 8'd0, byte_written: (out_capacity > cnt_c),
				end_of_string: 1'b1, decoded_length: cnt_c};
			n = n + 2'd1;
		end
	end

	assign bundle.n_words = n;
	assign bundle.words   = words;
	assign push           = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			value_q <= 9'd0;
			count_q <= 16'd0;
			full_q  <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				phase_q <= PH_NORMAL;
				value_q <= 9'd0;
				count_q <= 16'd0;
				full_q  <= 1'b0;
			end else begin
				phase_q <= ph_b;
				value_q <= val_b;
				count_q <= cnt_b;
				full_q  <= full_b;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/esd_queue.sv
// ----------------------------------------------------------------------------
// esd_queue
// short fifo of word bundles between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module esd_queue #(
	parameter int DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire esd_pkg::bundle_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output esd_pkg::bundle_t      head,
	output logic                  head_valid
);
	import esd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]   fill_q;
	logic            do_push, do_pop;

	assign full       = (fill_q == FW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/esd_back.sv
// ----------------------------------------------------------------------------
// esd_back
// unpacks bundles into single words behind an output register
// ----------------------------------------------------------------------------
`default_nettype none

module esd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire esd_pkg::bundle_t head,
	input  wire logic             head_valid,
	output logic                  pop,
	esd_out_if.source             byte_ch
);
	import esd_pkg::*;

	logic        out_valid_q;
	result_t     out_word_q;
	logic [1:0]  sub_q;
	logic        load;
	logic        last_sub;

	assign load     = !out_valid_q || byte_ch.ready;
	assign last_sub = (sub_q + 2'd1 >= head.n_words);
	assign pop      = load && head_valid && last_sub;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_word_q <= head.words[sub_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	assign byte_ch.valid          = out_valid_q;
	assign byte_ch.out_byte       = out_word_q.out_byte;
	assign byte_ch.byte_written   = out_word_q.byte_written;
	assign byte_ch.end_of_string  = out_word_q.end_of_string;
	assign byte_ch.decoded_length = out_word_q.decoded_length;

endmodule

`default_nettype wire

>>> design/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// decodes a c-style escaped string into bytes, a terminator and a length
// ----------------------------------------------------------------------------
// usage
//   char_ch: one escaped source character per word, is_last on the final one
//   byte_ch: decoded words; each carries the running decoded length, and the
//     last word of a string is the terminator with end_of_string set
//   cfg_wr_en / cfg_wr_data: out_capacity, written while the block is idle
// timing
//   a result reaches byte_ch through the bundle queue and the output register
//   one character per cycle is taken while each causes at most one word and
//     byte_ch is ready; a character causing two or three words holds the back
//     part as it sends them; the queue (QUEUE_DEPTH bundles) absorbs bursts
// reset
//   escape state, count and queue clear; out_capacity returns to 256
// stall
//   byte_ch holds its word while ready is low; char_ch keeps accepting
//   until the queue fills, then char_ch.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder #(
	parameter int QUEUE_DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [15:0]  cfg_wr_data,
	esd_in_if.sink            char_ch,
	esd_out_if.source         byte_ch
);
	import esd_pkg::*;

	// capacity register, applies from the next capacity check
	logic [15:0] out_capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			out_capacity_q <= cfg_wr_data;
		end
	end

	bundle_t front_bundle;
	bundle_t q_head;
	logic    front_push;
	logic    q_full;
	logic    q_head_valid;
	logic    back_pop;
	logic    accept;

	// front stalls only on a full queue
	assign char_ch.ready = !q_full;
	assign accept        = char_ch.valid && !q_full;

	esd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_in      (char_ch.char_in),
		.is_last      (char_ch.is_last),
		.out_capacity (out_capacity_q),
		.bundle       (front_bundle),
		.push         (front_push)
	);

	esd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_push),
		.push_data  (front_bundle),
		.full       (q_full),
		.pop        (back_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (back_pop),
		.byte_ch    (byte_ch)
	);

endmodule

`default_nettype wire

>>> design/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// port-level checks on the decoded word channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_sequence_decoder_defines.svh"

module esd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        byte_written,
	input wire logic        end_of_string,
	input wire logic [15:0] decoded_length
);

	// a stalled word holds
	`ESD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_written) && $stable(end_of_string) && $stable(decoded_length))

	// the terminator carries a zero byte
	`ESD_ASSERT_NOW(a_term_zero, out_valid && end_of_string, out_byte == 8'd0)

	// every decoded byte is stored
	`ESD_ASSERT_NOW(a_data_written, out_valid && !end_of_string, byte_written)

	// a decoded byte never reports an empty string
	`ESD_ASSERT_NOW(a_data_len, out_valid && !end_of_string, decoded_length != 16'd0)

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (byte_ch.valid),
	.out_ready      (byte_ch.ready),
	.out_byte       (byte_ch.out_byte),
	.byte_written   (byte_ch.byte_written),
	.end_of_string  (byte_ch.end_of_string),
	.decoded_length (byte_ch.decoded_length)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the escape sequence decoder against a cycle-free model of its
// decoding rules: characters go in through a queue-fed driver, every result
// word is compared in order with the words the model predicts, under changing
// buffer capacities and random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
	import esd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000; // cycles with no handshake on either channel
	localparam int IDLE_SETTLE    = 8;    // covers characters that cause no word
	localparam int END_SETTLE     = 20;
	localparam int MAX_REPORTS    = 10;

	// characters with a meaning to the decoder
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_N       = "n";
	localparam logic [7:0] CH_R       = "r";
	localparam logic [7:0] CH_T       = "t";
	localparam logic [7:0] CH_E       = "e";
	localparam logic [7:0] CH_X       = "x";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_SEVEN   = "7";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_F = "f";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_F = "F";
	// decoded values of the single-byte escapes
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_NUL   = 8'h00;

	// where the decoder stands inside an escape
	typedef enum logic [2:0] {
		ESC_NONE,
		ESC_OPEN,
		ESC_HEX_WAIT,
		ESC_HEX_ONE,
		ESC_OCT_ONE,
		ESC_OCT_TWO
	} esc_phase_t;

	// one character waiting to be driven
	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         drain_first; // hold it back until every expected word is in
	} char_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	esd_in_if  char_if();
	esd_out_if byte_if();

	escape_sequence_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.char_ch     (char_if),
		.byte_ch     (byte_if)
	);

	// stimulus and scoreboard storage
	char_item_t pend_q[$];
	result_t    exp_q[$];
	char_item_t drv_item;
	int         chars_queued   = 0;
	int         src_idle_pct   = 0;
	int         sink_stall_pct = 0;
	int         mismatch_cnt   = 0;
	int         stall_cycles   = 0;
	bit         char_taken     = 1'b0;
	string      hex_set        = "0123456789abcdefABCDEF";

	// decoder model state
	logic [15:0] capacity  = CAP_RESET;
	esc_phase_t  esc_phase = ESC_NONE;
	logic [8:0]  esc_value = '0;
	logic [15:0] dec_count = '0;
	logic        out_full  = 1'b0;

	// ------------------------------------------------------------------
	// decoder model
	// ------------------------------------------------------------------
	function automatic result_t make_word(logic [7:0] b, logic w, logic e, logic [15:0] n);
		result_t r;
		r.out_byte       = b;
		r.byte_written   = w;
		r.end_of_string  = e;
		r.decoded_length = n;
		return r;
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	function automatic bit is_octal(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_SEVEN;
	endfunction

	// a stored byte bumps the running length before it is reported
	function automatic void store_byte(logic [7:0] b);
		dec_count = dec_count + 16'd1;
		exp_q.push_back(make_word(b, 1'b1, 1'b0, dec_count));
	endfunction

	// a literal or a backslash: this is where the capacity is checked
	function automatic void start_item(logic [7:0] c);
		esc_phase = ESC_NONE;
		esc_value = '0;
		if ({1'b0, dec_count} + 17'd1 >= {1'b0, capacity}) begin
			out_full = 1'b1;
			return;
		end
		if (c == CH_BSLASH)
			esc_phase = ESC_OPEN;
		else
			store_byte(c);
	endfunction

	function automatic void continue_item(logic [7:0] c);
		int         h;
		logic [8:0] acc;
		h = hex_digit(c);
		acc = (esc_value << 3) + 9'(c - CH_ZERO);
		case (esc_phase)
			ESC_OPEN: begin
				esc_phase = ESC_NONE;
				case (c)
					CH_BSLASH: store_byte(CH_BSLASH);
					CH_QUOTE:  store_byte(CH_QUOTE);
					CH_N:      store_byte(BYTE_LF);
					CH_R:      store_byte(BYTE_CR);
					CH_T:      store_byte(BYTE_TAB);
					CH_E:      store_byte(BYTE_ESC);
					CH_X: begin
						esc_phase = ESC_HEX_WAIT;
						esc_value = '0;
					end
					default: begin
						if (is_octal(c)) begin
							esc_phase = ESC_OCT_ONE;
							esc_value = 9'(c - CH_ZERO);
						end else begin
							// unknown escape drops the backslash, keeps the char
							start_item(c);
						end
					end
				endcase
			end
			ESC_HEX_WAIT: begin
				if (h >= 0) begin
					esc_phase = ESC_HEX_ONE;
					esc_value = 9'(h);
				end else begin
					start_item(c);
				end
			end
			ESC_HEX_ONE: begin
				esc_phase = ESC_NONE;
				if (h >= 0) begin
					store_byte({esc_value[3:0], 4'(h)});
					esc_value = '0;
				end else begin
					store_byte(esc_value[7:0]);
					start_item(c);
				end
			end
			ESC_OCT_ONE: begin
				if (is_octal(c)) begin
					esc_phase = ESC_OCT_TWO;
					esc_value = acc;
				end else begin
					esc_phase = ESC_NONE;
					store_byte(esc_value[7:0]);
					start_item(c);
				end
			end
			ESC_OCT_TWO: begin
				esc_phase = ESC_NONE;
				if (is_octal(c)) begin
					// third digit: anything above 0377 is cut to a byte
					store_byte(acc[7:0]);
					esc_value = '0;
				end else begin
					store_byte(esc_value[7:0]);
					start_item(c);
				end
			end
			default: start_item(c);
		endcase
	endfunction

	// expected words for one accepted character
	function automatic void decode_char(logic [7:0] c, logic last);
		if (!out_full)
			continue_item(c);
		if (last) begin
			// flush a pending digit run; a bare backslash or \x gives nothing
			if (!out_full && (esc_phase == ESC_HEX_ONE || esc_phase == ESC_OCT_ONE ||
				esc_phase == ESC_OCT_TWO))
				store_byte(esc_value[7:0]);
			// terminator is stored only if the buffer still has room
			exp_q.push_back(make_word(BYTE_NUL, capacity > dec_count, 1'b1, dec_count));
			esc_phase = ESC_NONE;
			esc_value = '0;
			dec_count = '0;
			out_full  = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// character driver: takes the next word off the queue once the last
	// one was accepted, with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			char_if.valid <= 1'b0;
		end else if (!char_if.valid || char_taken) begin
			if (pend_q.size() != 0 && !(pend_q[0].drain_first && exp_q.size() != 0) &&
				$urandom_range(0, 99) >= src_idle_pct) begin
				drv_item = pend_q.pop_front();
				char_if.valid   <= 1'b1;
				char_if.char_in <= drv_item.ch;
				char_if.is_last <= drv_item.last;
			end else begin
				char_if.valid <= 1'b0;
			end
		end
	end

	// result sink: random back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			byte_if.ready <= 1'b0;
		else
			byte_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// ------------------------------------------------------------------
	// monitor: capacity writes and accepted characters feed the model,
	// accepted words are checked against the oldest expectation
	// ------------------------------------------------------------------
	task automatic flag_error(string what, result_t want, result_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t %s: expected byte %h wr %b eos %b len %0d, got byte %h wr %b eos %b len %0d",
				$realtime, what, want.out_byte, want.byte_written, want.end_of_string,
				want.decoded_length, got.out_byte, got.byte_written, got.end_of_string,
				got.decoded_length);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			char_taken = 1'b0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			char_taken = char_if.valid && char_if.ready;
			if (char_taken)
				decode_char(char_if.char_in, char_if.is_last);
			if (byte_if.valid && byte_if.ready) begin
				got = make_word(byte_if.out_byte, byte_if.byte_written,
					byte_if.end_of_string, byte_if.decoded_length);
				if (exp_q.size() == 0) begin
					flag_error("word with none expected", '0, got);
				end else begin
					want = exp_q.pop_front();
					if (got.out_byte !== want.out_byte ||
						got.byte_written !== want.byte_written ||
						got.end_of_string !== want.end_of_string ||
						got.decoded_length !== want.decoded_length)
						flag_error("word mismatch", want, got);
				end
			end
		end
	end

	// watchdog: a long run of cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("escape_sequence_decoder regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_char(logic [7:0] c, logic last, bit drain);
		char_item_t it;
		it.ch          = c;
		it.last        = last;
		it.drain_first = drain;
		pend_q.push_back(it);
		chars_queued++;
	endtask

	task automatic add_text(string txt, bit ends);
		for (int i = 0; i < txt.len(); i++)
			push_char(txt[i], ends && (i == txt.len() - 1), 1'b0);
	endtask

	// block idle: nothing queued, nothing on the channel, nothing owed
	task automatic wait_idle();
		while (pend_q.size() != 0 || char_if.valid || exp_q.size() != 0)
			@(negedge clk);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(logic [15:0] cap);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		// keep the first new character off the write edge
		@(negedge clk);
	endtask

	// mostly small buffers so the full case comes up often
	function automatic logic [15:0] pick_capacity();
		int k;
		k = $urandom_range(0, 99);
		if (k < 8) return 16'd0;
		if (k < 16) return 16'd1;
		if (k < 24) return 16'hFFFF;
		if (k < 32) return CAP_RESET;
		return 16'($urandom_range(2, 24));
	endfunction

	// a string built from well-formed escapes, literals and some noise
	task automatic add_random_string();
		logic [7:0] s[$];
		int         n_tok;
		int         kind;
		int         nd;
		bit         drain;
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			kind = $urandom_range(0, 99);
			if (kind < 22) begin
				s.push_back(8'($urandom_range(32, 126)));
			end else if (kind < 34) begin
				s.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 54) begin
				s.push_back(CH_BSLASH);
				case ($urandom_range(0, 5))
					0: s.push_back(CH_BSLASH);
					1: s.push_back(CH_QUOTE);
					2: s.push_back(CH_N);
					3: s.push_back(CH_R);
					4: s.push_back(CH_T);
					default: s.push_back(CH_E);
				endcase
			end else if (kind < 70) begin
				// \x with zero, one or two digits
				s.push_back(CH_BSLASH);
				s.push_back(CH_X);
				nd = $urandom_range(0, 2);
				repeat (nd) s.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
			end else if (kind < 86) begin
				s.push_back(CH_BSLASH);
				nd = $urandom_range(1, 3);
				repeat (nd) s.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end else if (kind < 95) begin
				// backslash then anything, mostly not a known escape
				s.push_back(CH_BSLASH);
				s.push_back(8'($urandom_range(0, 255)));
			end else begin
				s.push_back(CH_BSLASH);
			end
		end
		drain = ($urandom_range(0, 19) == 0);
		foreach (s[i])
			push_char(s[i], i == s.size() - 1, drain && i == 0);
	endtask

	task automatic run_round(int src_pct, int sink_pct, int n_chars);
		int target;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		target = chars_queued + n_chars;
		while (chars_queued < target) begin
			write_capacity(pick_capacity());
			repeat ($urandom_range(1, 4)) add_random_string();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		char_if.valid   = 1'b0;
		char_if.char_in = '0;
		char_if.is_last = 1'b0;
		byte_if.ready   = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct   = 6;
		sink_stall_pct = 75;

		// widest buffer: \e, two hex digits, octal overflow, \x with no digit,
		// unknown escape, extreme bytes, octal and hex runs cut short, and an
		// octal run flushed by the end of the string
		write_capacity(16'hFFFF);
		add_text("\\e\\xfF\\777\\xg", 1'b0);
		push_char(CH_BSLASH, 1'b0, 1'b1); // sender waits for all words first
		add_text("9", 1'b0);
		push_char(8'h00, 1'b0, 1'b0);
		add_text("\\18", 1'b0);
		push_char(8'hFF, 1'b0, 1'b0);
		add_text("\\x5z\\4", 1'b1);

		// room for one byte: the quote fits, the next char finds the buffer full
		write_capacity(16'd2);
		add_text("\\\"x", 1'b1);

		// no room at all: terminator not stored either
		write_capacity(16'd0);
		add_text("a", 1'b1);

		// capacity drops in the middle of an octal run: the run still lands
		write_capacity(CAP_RESET);
		add_text("\\1", 1'b0);
		write_capacity(16'd1);
		add_text("2x", 1'b1);

		run_round(6, 75, 115);
		run_round(75, 6, 115);
		run_round(0, 0, 120);

		wait_idle();
		repeat (END_SETTLE) @(negedge clk);
		if (mismatch_cnt == 0 && exp_q.size() == 0)
			$display("escape_sequence_decoder regression: pass");
		else
			$display("escape_sequence_decoder regression: fail");
		$finish;
	end

endmodule
